[hw/rtl/float_rgb_to_shared_exponent_unit_macros.svh]
// assertion macros for the shared exponent unit
`ifndef FLOAT_RGB_TO_SHARED_EXPONENT_UNIT_MACROS_SVH
`define FLOAT_RGB_TO_SHARED_EXPONENT_UNIT_MACROS_SVH
// implication checked on every clock edge outside reset
`define FRSE_ASSERT(label, clk, rst_n, prop, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) prop) else $error(msg);
`define FRSE_ASSERT_NEXT(label, clk, rst_n, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) ante |=> cons) else $error(msg);
`endif

[hw/rtl/frse_pkg.sv]
// package with types and constants for the shared exponent unit
package frse_pkg;
  localparam int unsigned ChanW = 32;
  localparam int unsigned MantW = 8;
  localparam int unsigned ExpW = 8;
  localparam int unsigned FracW = 23;
  localparam int unsigned ExpOffset = 134;
  localparam int unsigned MinMaxExp = 7;
  localparam int unsigned ShiftBase = 16;
  localparam int unsigned QueueDepth = 2;

  typedef struct packed {
    logic [ChanW-1:0] red;
    logic [ChanW-1:0] green;
    logic [ChanW-1:0] blue;
    logic [ExpW-1:0] max_exp;
    logic is_zero;
    logic bad;
  } job_t;

  typedef struct packed {
    logic [MantW-1:0] red_mant;
    logic [MantW-1:0] green_mant;
    logic [MantW-1:0] blue_mant;
    logic [ExpW-1:0] shared_exp;
    logic range_error;
  } res_t;
endpackage

[hw/rtl/frse_front.sv]
// front stage: classify the channels and find the largest exponent
module frse_front (
  input  logic [frse_pkg::ChanW-1:0] red_i,
  input  logic [frse_pkg::ChanW-1:0] green_i,
  input  logic [frse_pkg::ChanW-1:0] blue_i,
  output frse_pkg::job_t             job_o
);
  logic [frse_pkg::ChanW-1:0] mx;
  logic bad;
  logic [frse_pkg::ExpW-1:0] mexp;

  always_comb begin
    bad = red_i[31] | green_i[31] | blue_i[31]
        | (&red_i[30:23]) | (&green_i[30:23]) | (&blue_i[30:23]);
    mx = red_i;
    if (green_i > mx) mx = green_i;
    if (blue_i > mx) mx = blue_i;
    mexp = mx[30:23];
    job_o.red = red_i;
    job_o.green = green_i;
    job_o.blue = blue_i;
    job_o.max_exp = mexp;
    job_o.is_zero = !bad && (mx == '0);
    job_o.bad = bad || (mx != '0 && mexp < frse_pkg::ExpW'(frse_pkg::MinMaxExp));
  end
endmodule

[hw/rtl/frse_queue.sv]
// short queue between front and back
module frse_queue #(
  parameter int unsigned Depth = frse_pkg::QueueDepth
) (
  input  logic           clk_i,
  input  logic           rst_ni,
  input  logic           in_valid_i,
  output logic           in_ready_o,
  input  frse_pkg::job_t in_job_i,
  output logic           out_valid_o,
  input  logic           out_ready_i,
  output frse_pkg::job_t out_job_o
);
  localparam int unsigned PtrW = (Depth > 1) ? $clog2(Depth) : 1;
  frse_pkg::job_t mem_q [Depth];
  logic [PtrW-1:0] wr_q, wr_d, rd_q, rd_d;
  logic [PtrW:0] cnt_q, cnt_d;
  logic push, pop;

  assign in_ready_o = cnt_q != (PtrW+1)'(Depth);
  assign out_valid_o = cnt_q != '0;
  assign out_job_o = mem_q[rd_q];
  assign push = in_valid_i && in_ready_o;
  assign pop = out_valid_o && out_ready_i;

  always_comb begin
    wr_d = wr_q;
    rd_d = rd_q;
    if (push) wr_d = (wr_q == PtrW'(Depth-1)) ? '0 : wr_q + 1'b1;
    if (pop) rd_d = (rd_q == PtrW'(Depth-1)) ? '0 : rd_q + 1'b1;
    cnt_d = cnt_q + (PtrW+1)'(push) - (PtrW+1)'(pop);
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_q <= '0;
      rd_q <= '0;
      cnt_q <= '0;
    end else begin
      wr_q <= wr_d;
      rd_q <= rd_d;
      cnt_q <= cnt_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (push) mem_q[wr_q] <= in_job_i;
  end
endmodule

[hw/rtl/frse_back.sv]
// back stage: scale the channels and hold the result
module frse_back (
  input  logic           clk_i,
  input  logic           rst_ni,
  input  logic           in_valid_i,
  output logic           in_ready_o,
  input  frse_pkg::job_t in_job_i,
  output logic           out_valid_o,
  input  logic           out_ready_i,
  output frse_pkg::res_t out_res_o
);
  logic valid_q;
  frse_pkg::res_t res_q, res_d;

  function automatic logic [frse_pkg::MantW-1:0] scale(
    input logic [frse_pkg::ChanW-1:0] bits, input logic [frse_pkg::ExpW-1:0] mexp);
    logic [7:0] e;
    logic [23:0] m;
    logic [8:0] sh;
    logic [23:0] s;
    e = (bits[30:23] == '0) ? 8'd1 : bits[30:23];
    m = {bits[30:23] != '0, bits[22:0]};
    sh = {1'b0, mexp} - {1'b0, e} + 9'(frse_pkg::ShiftBase);
    s = m >> sh[4:0];
    if (e > mexp || sh >= 9'd32) scale = '0;
    else scale = s[7:0];
  endfunction

  assign in_ready_o = !valid_q || out_ready_i;
  assign out_valid_o = valid_q;
  assign out_res_o = res_q;

  always_comb begin
    res_d = '0;
    if (in_job_i.bad) begin
      res_d.range_error = 1'b1;
    end else if (!in_job_i.is_zero) begin
      res_d.red_mant = scale(in_job_i.red, in_job_i.max_exp);
      res_d.green_mant = scale(in_job_i.green, in_job_i.max_exp);
      res_d.blue_mant = scale(in_job_i.blue, in_job_i.max_exp);
      res_d.shared_exp = in_job_i.max_exp - frse_pkg::ExpW'(frse_pkg::ExpOffset);
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
    end else if (in_ready_o) begin
      valid_q <= in_valid_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_valid_i && in_ready_o) res_q <= res_d;
  end
endmodule

[hw/rtl/float_rgb_to_shared_exponent_unit.sv]
// top level: shared exponent color encoder
// an accepted input is written into the queue, then into the output register
// one item per cycle unless the output stalls; front classifies, back scales
// the two-entry queue lets the front keep accepting while the output stalls
// reset clears queue pointers and the output valid flag, no payload reset
module float_rgb_to_shared_exponent_unit #(
  parameter int unsigned QueueDepth = frse_pkg::QueueDepth
) (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        s_axis_tvalid,
  output logic        s_axis_tready,
  input  logic [95:0] s_axis_tdata,  // red_bits, green_bits, blue_bits
  output logic        m_axis_tvalid,
  input  logic        m_axis_tready,
  output logic [31:0] m_axis_tdata,  // red_mant, green_mant, blue_mant, shared_exp
  output logic        m_axis_tuser   // range_error
);
  frse_pkg::job_t fjob, qjob;
  frse_pkg::res_t res;
  logic q_valid, q_ready;

  frse_front u_front (
    .red_i(s_axis_tdata[31:0]), .green_i(s_axis_tdata[63:32]),
    .blue_i(s_axis_tdata[95:64]), .job_o(fjob)
  );

  frse_queue #(.Depth(QueueDepth)) u_queue (
    .clk_i, .rst_ni, .in_valid_i(s_axis_tvalid), .in_ready_o(s_axis_tready),
    .in_job_i(fjob), .out_valid_o(q_valid), .out_ready_i(q_ready), .out_job_o(qjob)
  );

  frse_back u_back (
    .clk_i, .rst_ni, .in_valid_i(q_valid), .in_ready_o(q_ready), .in_job_i(qjob),
    .out_valid_o(m_axis_tvalid), .out_ready_i(m_axis_tready), .out_res_o(res)
  );

  assign m_axis_tdata = {res.shared_exp, res.blue_mant, res.green_mant, res.red_mant};
  assign m_axis_tuser = res.range_error;
endmodule

[hw/rtl/frse_checker.sv]
// port checker for the shared exponent unit
`include "float_rgb_to_shared_exponent_unit_macros.svh"
module frse_checker (
  input logic        clk_i,
  input logic        rst_ni,
  input logic        s_axis_tvalid,
  input logic        s_axis_tready,
  input logic        m_axis_tvalid,
  input logic        m_axis_tready,
  input logic [31:0] m_axis_tdata,
  input logic        m_axis_tuser
);
  `FRSE_ASSERT(err_zero, clk_i, rst_ni, (m_axis_tvalid && m_axis_tuser) |-> (m_axis_tdata == '0), "error item with nonzero data")
  `FRSE_ASSERT(mant_norm, clk_i, rst_ni, (m_axis_tvalid && !m_axis_tuser && m_axis_tdata[31:24] != '0) |-> ((m_axis_tdata[7] | m_axis_tdata[15] | m_axis_tdata[23]) == 1'b1), "largest mantissa not normalized")
  `FRSE_ASSERT_NEXT(out_hold, clk_i, rst_ni, (m_axis_tvalid && !m_axis_tready), (m_axis_tvalid && $stable(m_axis_tdata)), "stalled output changed")
  `FRSE_ASSERT_NEXT(acc_out, clk_i, rst_ni, (s_axis_tvalid && s_axis_tready), ##1 m_axis_tvalid, "accepted item produced no output")
endmodule

bind float_rgb_to_shared_exponent_unit frse_checker u_frse_checker (.*);
